// ===== hdl/iq_line_accumulate_raster_assert.svh =====
// Assertion macros for the IQ line raster.
// Used by iq_line_accumulate_raster; needs nothing else.
`ifndef IQ_LINE_ACCUMULATE_RASTER_ASSERT_SVH
`define IQ_LINE_ACCUMULATE_RASTER_ASSERT_SVH

// same-cycle implication
`define IQLAR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IQLAR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/iqlar_pkg.sv =====
// Shared types and codes for the IQ line raster.
// No dependencies.
`timescale 1ns / 1ps

package iqlar_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_FADE   = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LINE,
    S_FADE,
    S_DRAIN,
    S_DONE
  } state_t;

  localparam logic REG_PIXEL_STEP = 1'b0;
  localparam logic REG_FADE_STEP  = 1'b1;

  localparam logic [7:0] PIX_LIMIT = 8'd255;
  localparam logic [7:0] IQ_OFFSET = 8'd128;

endpackage

// ===== hdl/iq_line_accumulate_raster.sv =====
// Top level of the IQ line raster: image memory, sequencer, config port.
// Depends on iqlar_pkg, iqlar_tracer and iq_line_accumulate_raster_assert.svh.
//
//  port group   dir  role              payload
//  s_*          in   item stream       tuser: op, batch_start; tdata: i, q, col, row
//  m_*          out  result stream     tdata: pixel_value; tuser: overflow_seen
//  p*           in   APB registers     pixel_step @0x0, fade_step @0x4
//
// Line item: one read-modify-write per cycle on the image memory.
// Fade item: one pixel per cycle; with fade_step zero, no pixel is touched.
// Read, batch-opening sample or unused op: no image pass, straight to the result.
// After reset a clearing pass zeroes the whole memory; s_tready stays low meanwhile.
// A waiting result is held in m_*; the next item is taken meanwhile.
`timescale 1ns / 1ps

module iq_line_accumulate_raster
  import iqlar_pkg::*;
#(
  parameter int IQ_RES = 256,
  parameter int SCALE  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // sample_i, sample_q, read_col, read_row, zero pad
  input  logic [2:0]  s_tuser,   // op, batch_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pixel_value
  output logic        m_tuser,   // overflow_seen
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SIDE  = IQ_RES * SCALE;
  localparam int DEPTH = SIDE * SIDE;
  localparam int CW    = $clog2(SIDE);
  localparam int MW    = $clog2(IQ_RES);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  // config
  logic [7:0] pixel_step, fade_step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_step <= 8'd4;
      fade_step  <= 8'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_PIXEL_STEP: pixel_step <= pwdata[7:0];
        REG_FADE_STEP:  fade_step  <= pwdata[7:0];
        default:        pixel_step <= pixel_step;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PIXEL_STEP: prdata = {24'd0, pixel_step};
      REG_FADE_STEP:  prdata = {24'd0, fade_step};
      default:        prdata = '0;
    endcase
  end

  // input fields
  logic [1:0]  in_op;
  logic [7:0]  in_i, in_q;
  logic        in_batch;
  logic [9:0]  in_rcol, in_rrow;
  logic        accept;

  assign in_op    = s_tuser[1:0];
  assign in_batch = s_tuser[2];
  assign in_i     = s_tdata[7:0];
  assign in_q     = s_tdata[15:8];
  assign in_rcol  = s_tdata[25:16];
  assign in_rrow  = s_tdata[35:26];
  assign accept   = s_tvalid && s_tready;

  function automatic logic [MW-1:0] map_raw(input logic [7:0] raw);
    logic [11:0] v;
    v = {4'd0, 8'(raw + IQ_OFFSET)};
    for (int k = 3; k >= 0; k--) begin
      if (v >= 12'(IQ_RES << k)) begin
        v = v - 12'(IQ_RES << k);
      end
    end
    return v[MW-1:0];
  endfunction

  logic [MW-1:0] new_col, new_row;
  logic [MW-1:0] prev_col, prev_row;
  logic [CW-1:0] sc0, sr0, sc1, sr1;
  logic          rd_in_area;
  logic [AW-1:0] rd_req_addr;

  assign new_col    = map_raw(in_i);
  assign new_row    = map_raw(in_q);
  assign sc0        = CW'(32'(prev_col) * SCALE);
  assign sr0        = CW'(32'(prev_row) * SCALE);
  assign sc1        = CW'(32'(new_col) * SCALE);
  assign sr1        = CW'(32'(new_row) * SCALE);
  assign rd_in_area = (32'(in_rcol) < SIDE) && (32'(in_rrow) < SIDE);
  assign rd_req_addr = rd_in_area ? AW'(32'(in_rrow) * SIDE + 32'(in_rcol)) : '0;

  // sequencer
  state_t        state, state_next;
  logic [AW-1:0] cnt;
  logic          trace_load, trace_step, trace_last;
  logic [CW-1:0] tr_col, tr_row;
  logic [AW-1:0] line_addr;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          issue_bump, issue_fade, out_load;
  logic          p1_bump, p1_fade;
  logic [AW-1:0] p1_addr;
  logic          read_ok;
  logic          overflow_flag;

  assign line_addr = AW'(32'(tr_row) * SIDE + 32'(tr_col));

  iqlar_tracer #(
    .CW(CW)
  ) u_tracer (
    .clk  (clk),
    .load (trace_load),
    .step (trace_step),
    .c0   (sc0),
    .r0   (sr0),
    .c1   (sc1),
    .r1   (sr1),
    .col  (tr_col),
    .row  (tr_row),
    .last (trace_last)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (cnt == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_SAMPLE: state_next = in_batch ? S_DONE : S_LINE;
            OP_FADE:   state_next = (fade_step != 8'd0) ? S_FADE : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_LINE:  if (trace_last) state_next = S_DRAIN;
      S_FADE:  if (cnt == LAST_ADDR) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    trace_load = 1'b0;
    trace_step = 1'b0;
    issue_bump = 1'b0;
    issue_fade = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        trace_load = accept && (in_op == OP_SAMPLE) && !in_batch;
        rd_en      = accept && (in_op == OP_READ);
        rd_addr    = rd_req_addr;
      end
      S_LINE: begin
        rd_en      = 1'b1;
        rd_addr    = line_addr;
        issue_bump = (tr_col != '0) && (tr_row != '0);
        trace_step = !trace_last;
      end
      S_FADE: begin
        rd_en      = 1'b1;
        rd_addr    = cnt;
        issue_fade = 1'b1;
      end
      S_DONE:  out_load = !m_tvalid || m_tready;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      p1_bump  <= 1'b0;
      p1_fade  <= 1'b0;
      prev_col <= '0;
      prev_row <= '0;
      read_ok  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      p1_bump <= issue_bump;
      p1_fade <= issue_fade;
      if (state == S_CLEAR || state == S_FADE) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (accept) begin
        read_ok <= (in_op == OP_READ) && rd_in_area;
        if (in_op == OP_SAMPLE) begin
          prev_col <= new_col;
          prev_row <= new_row;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_bump || issue_fade) begin
      p1_addr <= rd_addr;
    end
    if (out_load) begin
      m_tdata <= read_ok ? rd_data : 8'd0;
      m_tuser <= overflow_flag;
    end
  end

  // write-back stage
  logic [8:0]    bump_sum;
  logic          ovf_set;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_comb begin
    bump_sum = {1'b0, rd_data} + {1'b0, pixel_step};
    ovf_set  = p1_bump && (bump_sum >= {1'b0, PIX_LIMIT});
    wr_en    = 1'b0;
    wr_addr  = p1_addr;
    wr_data  = bump_sum[7:0];
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt;
      wr_data = 8'd0;
    end else if (p1_bump) begin
      wr_en = !ovf_set;
    end else if (p1_fade) begin
      wr_en   = 1'b1;
      wr_data = (rd_data > fade_step) ? rd_data - fade_step : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_flag <= 1'b0;
    end else if (ovf_set) begin
      overflow_flag <= 1'b1;
    end
  end

  // image memory
  logic [7:0] image_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      image_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= image_mem[rd_addr];
    end
  end

  `include "iq_line_accumulate_raster_assert.svh"

  `IQLAR_ASSERT_IMP(a_pipe_drained, clk, rst, (p1_bump || p1_fade), (state != S_IDLE), "write-back pending while idle")
  `IQLAR_ASSERT_NXT(a_flag_sticky, clk, rst, overflow_flag, overflow_flag, "overflow flag dropped")
  `IQLAR_ASSERT_NXT(a_read_done, clk, rst, (accept && in_op == OP_READ), (state == S_DONE), "read did not finish at once")
  `IQLAR_ASSERT_NXT(a_line_drain, clk, rst, (state == S_LINE && trace_last), (state == S_DRAIN && !p1_fade), "line end not drained")

endmodule

// ===== hdl/iqlar_tracer.sv =====
// Bresenham line stepper: one pixel per step from a start to an end point.
// Standalone; no package needed.
`timescale 1ns / 1ps

module iqlar_tracer #(
  parameter int CW = 10
) (
  input  logic          clk,
  input  logic          load,
  input  logic          step,
  input  logic [CW-1:0] c0,
  input  logic [CW-1:0] r0,
  input  logic [CW-1:0] c1,
  input  logic [CW-1:0] r1,
  output logic [CW-1:0] col,
  output logic [CW-1:0] row,
  output logic          last
);

  localparam int EW = CW + 2;

  logic [CW-1:0]        cur_c, cur_r, end_c, end_r;
  logic signed [EW-1:0] dc, dr, err;
  logic                 sc_neg, sr_neg;

  logic signed [EW-1:0] dc_ld, dr_ld, err_ld, err_next;
  logic                 mv_c, mv_r;

  always_comb begin
    dc_ld = $signed({2'b00, c1}) - $signed({2'b00, c0});
    dr_ld = $signed({2'b00, r1}) - $signed({2'b00, r0});
    if (dc_ld < 0) begin
      dc_ld = -dc_ld;
    end
    if (dr_ld < 0) begin
      dr_ld = -dr_ld;
    end
    if (dc_ld > dr_ld) begin
      err_ld = dc_ld >>> 1;
    end else begin
      err_ld = -(dr_ld >>> 1);
    end
  end

  always_comb begin
    mv_c     = err > -dc;
    mv_r     = err < dr;
    err_next = err - (mv_c ? dr : '0) + (mv_r ? dc : '0);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_c  <= c0;
      cur_r  <= r0;
      end_c  <= c1;
      end_r  <= r1;
      dc     <= dc_ld;
      dr     <= dr_ld;
      err    <= err_ld;
      sc_neg <= !(c0 < c1);
      sr_neg <= !(r0 < r1);
    end else if (step) begin
      err <= err_next;
      if (mv_c) begin
        cur_c <= sc_neg ? cur_c - 1'b1 : cur_c + 1'b1;
      end
      if (mv_r) begin
        cur_r <= sr_neg ? cur_r - 1'b1 : cur_r + 1'b1;
      end
    end
  end

  assign col  = cur_c;
  assign row  = cur_r;
  assign last = (cur_c == end_c) && (cur_r == end_r);

endmodule

// ===== sim/iq_raster_checker.sv =====
// Checker for the IQ line raster: watches the item, result and register channels,
// keeps its own copy of the image and counts mismatching results.
// Depends on iqlar_pkg.
`timescale 1ns / 1ps

module iq_raster_checker
  import iqlar_pkg::*;
#(
  parameter int IQ_RES = 256,
  parameter int SCALE  = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // sample_i, sample_q, read_col, read_row, zero pad
  input  logic [2:0]  s_tuser,   // op, batch_start
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // pixel_value
  input  logic        m_tuser,   // overflow_seen
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          results_pending
);

  localparam int SIDE = IQ_RES * SCALE;

  typedef struct packed {
    logic [7:0] pixel;
    logic       overflow;
  } raster_result_t;

  bit [7:0]       image [SIDE*SIDE];
  int             last_col;
  int             last_row;
  bit             overflow_sticky;
  logic [7:0]     step_up;
  logic [7:0]     step_down;
  raster_result_t results_due [$];

  function automatic int axis_position(input logic [7:0] raw);
    logic [7:0] shifted;
    shifted = raw + IQ_OFFSET;
    return (int'(shifted) % IQ_RES) * SCALE;
  endfunction

  function automatic void raise_pixel(input int col, input int row);
    int v;
    if (col <= 0 || row <= 0 || col >= SIDE || row >= SIDE) return;
    v = image[row*SIDE + col];
    if (v + int'(step_up) >= int'(PIX_LIMIT)) overflow_sticky = 1'b1;
    else image[row*SIDE + col] = 8'(v + int'(step_up));
  endfunction

  function automatic void trace_segment(input int c0, input int r0, input int c1, input int r1);
    int  dc, dr, sc, sr, err, e;
    bit  done;
    dc = c1 > c0 ? c1 - c0 : c0 - c1;
    dr = r1 > r0 ? r1 - r0 : r0 - r1;
    sc = c0 < c1 ? 1 : -1;
    sr = r0 < r1 ? 1 : -1;
    err = dc > dr ? dc / 2 : -(dr / 2);
    done = 1'b0;
    while (!done) begin
      raise_pixel(c0, r0);
      if (c0 == c1 && r0 == r1) begin
        done = 1'b1;
      end else begin
        e = err;
        if (e > -dc) begin
          err -= dr;
          c0 += sc;
        end
        if (e < dr) begin
          err += dc;
          r0 += sr;
        end
      end
    end
  endfunction

  function automatic raster_result_t apply_item(input logic [2:0] user, input logic [39:0] data);
    raster_result_t res;
    int col, row;
    res = '0;
    case (user[1:0])
      OP_SAMPLE: begin
        col = axis_position(data[7:0]);
        row = axis_position(data[15:8]);
        if (!user[2]) trace_segment(last_col, last_row, col, row);
        last_col = col;
        last_row = row;
      end
      OP_FADE: begin
        if (step_down != 8'd0)
          for (int k = 0; k < SIDE*SIDE; k++)
            image[k] = image[k] > step_down ? image[k] - step_down : 8'd0;
      end
      OP_READ: begin
        col = int'(data[25:16]);
        row = int'(data[35:26]);
        if (col < SIDE && row < SIDE) res.pixel = image[row*SIDE + col];
      end
      default: ;
    endcase
    res.overflow = overflow_sticky;
    return res;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", what);
  endfunction

  always @(posedge clk) begin : watch
    raster_result_t want;
    if (rst) begin
      last_col = 0;
      last_row = 0;
      overflow_sticky = 1'b0;
      step_up = 8'd4;
      step_down = 8'd0;
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PIXEL_STEP) step_up = pwdata[7:0];
        else step_down = pwdata[7:0];
      end
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected result at %0t: pixel %0d overflow %0b",
                                  $realtime, m_tdata, m_tuser));
        end else begin
          want = results_due.pop_front();
          if (want.pixel !== m_tdata || want.overflow !== m_tuser)
            note_mismatch($sformatf(
              "mismatch at %0t: expected pixel %0d overflow %0b, got pixel %0d overflow %0b",
              $realtime, want.pixel, want.overflow, m_tdata, m_tuser));
        end
      end
      if (s_tvalid && s_tready) results_due.push_back(apply_item(s_tuser, s_tdata));
    end
    results_pending = results_due.size();
  end

endmodule

// ===== sim/tb_iq_line_accumulate_raster.sv =====
// Testbench top for the IQ line raster: clock, reset, item and register stimulus,
// random back-pressure and the verdict. Depends on iqlar_pkg, iq_raster_checker
// and iq_line_accumulate_raster.
`timescale 1ns / 1ps

module tb_iq_line_accumulate_raster;
  import iqlar_pkg::*;

  localparam int         IQ_RES       = 256;
  localparam int         SCALE        = 4;
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         HOLD_CYCLES  = 500;
  localparam int         SETTLE_LIMIT = 2_000_000;
  localparam longint     RUN_LIMIT_NS = 200_000_000;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] si;
    logic [7:0] sq;
    logic       batch;
    logic [9:0] col;
    logic [9:0] row;
  } raster_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // sample_i, sample_q, read_col, read_row, zero pad
  logic [2:0]  s_tuser;   // op, batch_start
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // pixel_value
  logic        m_tuser;   // overflow_seen
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatch_count;
  int          results_pending;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_req = 1'b0;
  logic [9:0]  seen_col [8];
  logic [9:0]  seen_row [8];
  int          seen_next = 0;

  always #5 clk = ~clk;

  iq_line_accumulate_raster #(.IQ_RES(IQ_RES), .SCALE(SCALE)) u_top (.*);

  iq_raster_checker #(.IQ_RES(IQ_RES), .SCALE(SCALE)) u_raster_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count, .results_pending
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(20, 4);
    return $urandom_range(200, 30);
  endfunction

  function automatic raster_item_t sample_item(input logic [7:0] si, input logic [7:0] sq,
                                               input logic batch);
    raster_item_t it;
    it = '0;
    it.op = OP_SAMPLE;
    it.si = si;
    it.sq = sq;
    it.batch = batch;
    return it;
  endfunction

  function automatic raster_item_t read_item(input logic [9:0] col, input logic [9:0] row);
    raster_item_t it;
    it = '0;
    it.op = OP_READ;
    it.col = col;
    it.row = row;
    return it;
  endfunction

  function automatic raster_item_t op_item(input logic [1:0] op);
    raster_item_t it;
    it.op = op;
    it.si = 8'($urandom);
    it.sq = 8'($urandom);
    it.batch = 1'($urandom);
    it.col = 10'($urandom);
    it.row = 10'($urandom);
    return it;
  endfunction

  task automatic send_item(input raster_item_t it);
    int gap;
    gap = (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, it.row, it.col, it.sq, it.si};
    s_tuser <= {it.batch, it.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (it.op == OP_SAMPLE) begin
      seen_col[seen_next] = {~it.si[7], it.si[6:0], 2'b00};
      seen_row[seen_next] = {~it.sq[7], it.sq[6:0], 2'b00};
      seen_next = (seen_next + 1) % 8;
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (results_pending != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(input logic sel, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(input int n, input int fade_at, input int hold_at,
                           input int cluster_pct, input bit cheap_fade);
    raster_item_t it;
    logic [7:0]   base_i, base_q;
    int           pick, h, jc, jr;
    base_i = 8'($urandom);
    base_q = 8'($urandom);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (k == fade_at) begin
        it = op_item(OP_FADE);
      end else if (pick < 55) begin
        if ($urandom_range(99) < cluster_pct) begin
          if ($urandom_range(15) == 0) begin
            base_i = 8'($urandom);
            base_q = 8'($urandom);
          end
          it = sample_item(base_i + 8'($urandom_range(3)), base_q + 8'($urandom_range(3)),
                           $urandom_range(9) == 0);
        end else begin
          it = sample_item(8'($urandom), 8'($urandom), $urandom_range(9) == 0);
        end
      end else if (pick < 90) begin
        if ($urandom_range(9) < 7) begin
          h = $urandom_range(7);
          jc = ($urandom_range(3) == 0) ? int'($urandom_range(2)) - 1 : 0;
          jr = ($urandom_range(3) == 0) ? int'($urandom_range(2)) - 1 : 0;
          it = read_item(10'(int'(seen_col[h]) + jc), 10'(int'(seen_row[h]) + jr));
        end else begin
          it = read_item(10'($urandom), 10'($urandom));
        end
      end else if (pick < 95) begin
        it = op_item(OP_UNUSED);
      end else begin
        it = cheap_fade ? op_item(OP_FADE) : read_item(10'($urandom), 10'($urandom));
      end
      send_item(it);
    end
  endtask

  // receiver: random stalls, and a long hold-off on request
  initial begin : receiver
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (seen_col[k]) begin
      seen_col[k] = '0;
      seen_row[k] = '0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // image clearing pass after reset
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    reg_write(REG_PIXEL_STEP, 8'd4);
    reg_write(REG_FADE_STEP, 8'd0);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_item(read_item(10'd0, 10'd0));
    send_item(raster_item_t'('1));
    send_item(sample_item(8'd128, 8'd128, 1'b1));
    send_item(sample_item(8'd127, 8'd128, 1'b0));
    send_item(read_item(10'd1020, 10'd0));
    send_item(sample_item(8'd127, 8'd127, 1'b0));
    send_item(read_item(10'd1020, 10'd1020));
    send_item(sample_item(8'd127, 8'd127, 1'b0));
    send_item(read_item(10'd1020, 10'd1020));
    send_item(sample_item(8'd129, 8'd129, 1'b0));
    send_item(read_item(10'd512, 10'd512));
    send_item(read_item(10'd4, 10'd4));
    send_item(sample_item(8'd0, 8'd255, 1'b1));
    send_item(sample_item(8'd255, 8'd0, 1'b0));
    send_item(read_item(10'd508, 10'd512));
    send_item(read_item(10'd1023, 10'd1023));
    send_item(op_item(OP_FADE));
    send_item(read_item(10'd1020, 10'd1020));
    send_item(read_item(10'd1023, 10'd0));
    send_item(read_item(10'd0, 10'd1023));
    send_item(sample_item(8'd0, 8'd0, 1'b0));
    send_item(read_item(10'd512, 10'd512));

    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(120, -1, -1, 40, 1'b1);

    settle();
    reg_write(REG_PIXEL_STEP, 8'd1);
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    run_phase(120, -1, 60, 80, 1'b1);

    settle();
    reg_write(REG_PIXEL_STEP, 8'd0);
    tx_idle_pct = 15;
    rx_idle_pct = 40;
    run_phase(80, -1, -1, 50, 1'b1);

    settle();
    reg_write(REG_PIXEL_STEP, 8'($urandom_range(40, 5)));
    reg_write(REG_FADE_STEP, 8'($urandom_range(254, 1)));
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    run_phase(140, 70, -1, 70, 1'b0);

    settle();
    reg_write(REG_PIXEL_STEP, 8'd255);
    reg_write(REG_FADE_STEP, 8'd255);
    tx_idle_pct = 40;
    rx_idle_pct = 40;
    run_phase(120, 80, -1, 50, 1'b0);

    settle();
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/iqlar_pkg.sv
hdl/iqlar_tracer.sv
hdl/iq_line_accumulate_raster.sv
sim/iq_raster_checker.sv
sim/tb_iq_line_accumulate_raster.sv
